>>> hdl/swec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter package
// Shared constants, types and operation codes of the counter and its
// arithmetic unit.
// ----------------------------------------------------------------------------
package swec_pkg;

    localparam int QUEUE_DEPTH  = 512;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int OCC_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W      = 32;
    localparam int STAMP_W      = 32;
    localparam int WLEN_W       = 10;
    localparam int PADDR_W      = 2;
    localparam int PDATA_W      = 32;

    localparam logic [WLEN_W-1:0]  WINDOW_RESET = WLEN_W'(300);
    localparam logic [PADDR_W-1:0] ADDR_WINDOW  = PADDR_W'(0);

    // Arithmetic unit operations
    localparam logic [1:0] ALU_ADD_SAT   = 2'd0;
    localparam logic [1:0] ALU_SUB_FLOOR = 2'd1;
    localparam logic [1:0] ALU_OLD       = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] b;
        logic [STAMP_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [COUNT_W-1:0] value;
        logic               flag;
    } t_alu_rsp;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

>>> hdl/swec_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket store
// Single write port, single read port memory holding the closed buckets,
// with registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module swec_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [swec_pkg::PTR_W-1:0]  i_waddr,
    input  swec_pkg::t_entry            i_wdata,
    input  logic                        i_re,
    input  logic [swec_pkg::PTR_W-1:0]  i_raddr,
    output swec_pkg::t_entry            o_rdata
);
    import swec_pkg::*;

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/swec_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// One 33-bit adder used for saturating add, floored subtract and the
// window age test.
// ----------------------------------------------------------------------------
module swec_alu (
    input  swec_pkg::t_alu_req i_req,
    output swec_pkg::t_alu_rsp o_rsp
);
    import swec_pkg::*;

    logic                 sub;
    logic [COUNT_W:0]     sum;

    assign sub = (i_req.op == ALU_SUB_FLOOR);
    assign sum = {1'b0, i_req.a} + {1'b0, (sub ? ~i_req.b : i_req.b)} + {{COUNT_W{1'b0}}, sub};

    always_comb begin
        o_rsp = '0;
        case (i_req.op)
            ALU_ADD_SAT: begin
                o_rsp.value = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
            end
            ALU_SUB_FLOOR: begin
                // A carry out means a >= b; equal operands give zero anyway.
                o_rsp.value = sum[COUNT_W] ? sum[COUNT_W-1:0] : '0;
            end
            ALU_OLD: begin
                // Stamp plus window length, compared without wrap.
                o_rsp.flag = (sum <= {1'b0, i_req.c});
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

>>> hdl/sliding_window_event_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window event counter
// Counts hits in a sliding time window using a FIFO of per-timestamp buckets,
// a running window total and a sequencer around one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Sequence: a hit adds one to the open bucket when the timestamp matches,
// else closes it into the store, dropping the oldest bucket first when full;
// then buckets out of the window are evicted (read, age test, subtract). A
// query evicts likewise, restarts a stale open bucket and registers its
// result word. Requests are taken one at a time, only in the idle state.
// Synchronous active-low reset clears the FIFO pointers and sets window 300.
// ----------------------------------------------------------------------------
module sliding_window_event_counter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic [swec_pkg::STAMP_W-1:0]  i_timestamp,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [swec_pkg::COUNT_W-1:0]  o_hit_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swec_pkg::PADDR_W-1:0]  paddr,
    input  logic [swec_pkg::PDATA_W-1:0]  pwdata,
    output logic [swec_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import swec_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_HIT   = 4'd1;
    localparam logic [3:0] ST_DRD   = 4'd2;
    localparam logic [3:0] ST_DSUB  = 4'd3;
    localparam logic [3:0] ST_CLOSE = 4'd4;
    localparam logic [3:0] ST_EVRD  = 4'd5;
    localparam logic [3:0] ST_EVCHK = 4'd6;
    localparam logic [3:0] ST_EVSUB = 4'd7;
    localparam logic [3:0] ST_STALE = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [3:0]         r_state, n_state;
    logic               r_op, n_op;
    logic [STAMP_W-1:0] r_now, n_now;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [COUNT_W-1:0] r_total, n_total;
    logic [COUNT_W-1:0] r_cur_count, n_cur_count;
    logic [STAMP_W-1:0] r_cur_stamp, n_cur_stamp;
    logic [WLEN_W-1:0]  r_wlen, n_wlen;
    logic               r_ovalid, n_ovalid;
    logic [COUNT_W-1:0] r_hit_count, n_hit_count;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     mem_we;
    logic     mem_re;
    t_entry   mem_wdata;
    t_entry   mem_rdata;
    logic     cfg_write;

    swec_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    swec_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_tail),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_WINDOW);
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_WINDOW) ? PDATA_W'(r_wlen) : '0;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_hit_count = r_hit_count;
    assign mem_wdata   = '{count: r_cur_count, stamp: r_cur_stamp};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_now       = r_now;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_total     = r_total;
        n_cur_count = r_cur_count;
        n_cur_stamp = r_cur_stamp;
        n_wlen      = cfg_write ? pwdata[WLEN_W-1:0] : r_wlen;
        n_ovalid    = (r_ovalid && i_ready) ? 1'b0 : r_ovalid;
        n_hit_count = r_hit_count;
        alu_req     = '{op: ALU_ADD_SAT, a: r_total, b: r_cur_count, c: r_now};
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_now   = i_timestamp;
                    n_state = i_operation ? ST_EVRD : ST_HIT;
                end
            end
            ST_HIT: begin
                if (r_now == r_cur_stamp) begin
                    alu_req     = '{op: ALU_ADD_SAT, a: r_cur_count, b: COUNT_W'(1), c: r_now};
                    n_cur_count = alu_rsp.value;
                    n_state     = ST_EVRD;
                end else if (r_occ >= OCC_FULL) begin
                    n_state = ST_DRD;
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_DRD: begin
                mem_re  = 1'b1;
                n_state = ST_DSUB;
            end
            ST_DSUB: begin
                // Full store: the oldest bucket leaves to make room.
                alu_req = '{op: ALU_SUB_FLOOR, a: r_total, b: mem_rdata.count, c: r_now};
                n_total = alu_rsp.value;
                n_head  = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                n_occ   = r_occ - OCC_W'(1);
                n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                mem_we      = 1'b1;
                alu_req     = '{op: ALU_ADD_SAT, a: r_total, b: r_cur_count, c: r_now};
                n_total     = alu_rsp.value;
                n_tail      = (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                n_occ       = r_occ + OCC_W'(1);
                n_cur_count = COUNT_W'(1);
                n_cur_stamp = r_now;
                n_state     = ST_EVRD;
            end
            ST_EVRD: begin
                if (r_occ == '0) begin
                    n_state = r_op ? ST_STALE : ST_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_EVCHK;
                end
            end
            ST_EVCHK: begin
                alu_req = '{op: ALU_OLD, a: mem_rdata.stamp, b: COUNT_W'(r_wlen), c: r_now};
                if (alu_rsp.flag) begin
                    n_state = ST_EVSUB;
                end else begin
                    n_state = r_op ? ST_STALE : ST_IDLE;
                end
            end
            ST_EVSUB: begin
                alu_req = '{op: ALU_SUB_FLOOR, a: r_total, b: mem_rdata.count, c: r_now};
                n_total = alu_rsp.value;
                n_head  = (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                n_occ   = r_occ - OCC_W'(1);
                n_state = ST_EVRD;
            end
            ST_STALE: begin
                // A stale open bucket restarts empty at the query time.
                alu_req = '{op: ALU_OLD, a: r_cur_stamp, b: COUNT_W'(r_wlen), c: r_now};
                if (alu_rsp.flag) begin
                    n_cur_count = '0;
                    n_cur_stamp = r_now;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                alu_req = '{op: ALU_ADD_SAT, a: r_total, b: r_cur_count, c: r_now};
                if (!r_ovalid || i_ready) begin
                    n_hit_count = alu_rsp.value;
                    n_ovalid    = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_total     <= '0;
            r_cur_count <= '0;
            r_cur_stamp <= '0;
            r_wlen      <= WINDOW_RESET;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_total     <= n_total;
            r_cur_count <= n_cur_count;
            r_cur_stamp <= n_cur_stamp;
            r_wlen      <= n_wlen;
            r_ovalid    <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_now       <= n_now;
        r_hit_count <= n_hit_count;
    end

endmodule
